// File: rtl/core/sbmv_pkg.sv
package sbmv_pkg;

   localparam int SECTOR_BYTES = 512;
   localparam int MAX_PASSES   = 15;

   localparam int POS_W = $clog2(SECTOR_BYTES);
   localparam int CNT_W = $clog2(MAX_PASSES + 1);
   localparam int TOT_W = 13;
   localparam int MEM_W = 8 * CNT_W;

   localparam logic [POS_W-1:0] LAST_POS   = POS_W'(SECTOR_BYTES - 1);
   localparam logic [CNT_W-1:0] PASS_LIMIT = CNT_W'(MAX_PASSES);
   localparam logic [TOT_W-1:0] TOTAL_MAX  = '1;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [1:0] {
      SECTOR_FAILED    = 2'd0,
      SECTOR_STABLE    = 2'd1,
      SECTOR_RECOVERED = 2'd2,
      SECTOR_UNCERTAIN = 2'd3
   } sector_status_type;

   typedef enum logic {
      ACT_VOTE = 1'b0,
      ACT_READ = 1'b1
   } action_type;

   // controller to datapath
   typedef struct packed {
      logic capture;    // request accepted, latch it and read its counters
      logic exec_vote;  // add the latched byte as votes
      logic exec_read;  // rebuild the byte and load the result register
      logic clr_step;   // zero one memory row
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      action_type action;
      logic       at_end;
      logic       out_free;
      logic       clr_last;
   } stat_type;

endpackage

// File: rtl/core/sbmv_ctrl.sv
module sbmv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sbmv_pkg::stat_type stat,
   output sbmv_pkg::cmd_type  cmd
);
   import sbmv_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_tready    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.action == ACT_VOTE) begin
               cmd.exec_vote = 1'b1;
               state_in      = S_IDLE;
            end else if (stat.out_free) begin
               cmd.exec_read = 1'b1;
               // final byte of the readout wipes the counters
               state_in      = stat.at_end ? S_CLEAR : S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/sbmv_dp.sv
module sbmv_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sbmv_pkg::cmd_type                    cmd,
   output sbmv_pkg::stat_type                   stat,
   input  logic                                 req_tuser,
   input  logic [sbmv_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sbmv_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tlast
);
   import sbmv_pkg::*;

   logic [MEM_W-1:0] vote_mem [SECTOR_BYTES];

   action_type        action_ff;
   logic [7:0]        data_ff;
   logic [MEM_W-1:0]  rd_data_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  clr_addr_ff;
   logic [CNT_W-1:0]  pass_ff, pass_in;
   logic [TOT_W-1:0]  flick_tot_ff, flick_tot_in;
   logic [TOT_W-1:0]  doubt_tot_ff, doubt_tot_in;
   logic              out_valid_ff;
   logic [7:0]        out_byte_ff;
   logic [3:0]        out_flick_ff, out_doubt_ff;
   logic              out_last_ff;
   sector_status_type out_status_ff;
   logic [TOT_W-1:0]  out_flick_tot_ff, out_doubt_tot_ff;

   logic              at_end;
   logic              out_free;
   logic              can_vote;
   logic [MEM_W-1:0]  vote_word;
   logic [CNT_W-1:0]  half;
   logic [CNT_W-1:0]  lane_ones  [8];
   logic [CNT_W-1:0]  lane_zeros [8];
   logic [CNT_W-1:0]  lane_win   [8];
   logic [CNT_W+1:0]  lane_win3  [8];
   logic [CNT_W+1:0]  pass2;
   logic [7:0]        lane_flick, lane_doubt, rebuilt;
   logic [3:0]        flick_cnt, doubt_cnt;
   logic [TOT_W:0]    flick_sum, doubt_sum;
   sector_status_type status;

   assign at_end   = (pos_ff == LAST_POS);
   assign out_free = !out_valid_ff || rsp_tready;
   assign can_vote = (pass_ff < PASS_LIMIT);

   assign stat.action   = action_ff;
   assign stat.at_end   = at_end;
   assign stat.out_free = out_free;
   assign stat.clr_last = (clr_addr_ff == LAST_POS);

   // eight counters of the addressed row, one lane per bit
   always_comb begin
      half  = pass_ff >> 1;
      pass2 = (CNT_W+2)'({pass_ff, 1'b0});
      for (int i = 0; i < 8; i++) begin
         vote_word[i*CNT_W +: CNT_W] = rd_data_ff[i*CNT_W +: CNT_W]
                                       + CNT_W'(data_ff[i] & can_vote);
         lane_ones[i]  = (rd_data_ff[i*CNT_W +: CNT_W] > pass_ff)
                         ? pass_ff : rd_data_ff[i*CNT_W +: CNT_W];
         lane_zeros[i] = pass_ff - lane_ones[i];
         lane_win[i]   = (lane_ones[i] > lane_zeros[i]) ? lane_ones[i] : lane_zeros[i];
         lane_win3[i]  = (CNT_W+2)'(lane_win[i]) * (CNT_W+2)'(3);
         rebuilt[i]    = (lane_ones[i] > half);
         lane_flick[i] = (lane_ones[i] != '0) && (lane_zeros[i] != '0);
         lane_doubt[i] = lane_flick[i] && (lane_win3[i] < pass2);
      end
   end

   always_comb begin
      flick_cnt = '0;
      doubt_cnt = '0;
      for (int i = 0; i < 8; i++) begin
         flick_cnt = flick_cnt + 4'(lane_flick[i]);
         doubt_cnt = doubt_cnt + 4'(lane_doubt[i]);
      end
      flick_sum = (TOT_W+1)'(flick_tot_ff) + (TOT_W+1)'(flick_cnt);
      doubt_sum = (TOT_W+1)'(doubt_tot_ff) + (TOT_W+1)'(doubt_cnt);
      flick_tot_in = flick_sum[TOT_W] ? TOTAL_MAX : flick_sum[TOT_W-1:0];
      doubt_tot_in = doubt_sum[TOT_W] ? TOTAL_MAX : doubt_sum[TOT_W-1:0];
      priority if (pass_ff == '0) begin
         status = SECTOR_FAILED;
      end else if (flick_tot_in == '0) begin
         status = SECTOR_STABLE;
      end else if (doubt_tot_in == '0) begin
         status = SECTOR_RECOVERED;
      end else begin
         status = SECTOR_UNCERTAIN;
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      pass_in = pass_ff;
      if (cmd.exec_vote) begin
         pos_in = at_end ? '0 : pos_ff + POS_W'(1);
         if (at_end && can_vote) begin
            pass_in = pass_ff + CNT_W'(1);
         end
      end else if (cmd.exec_read) begin
         pos_in = at_end ? '0 : pos_ff + POS_W'(1);
         if (at_end) begin
            pass_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         pass_ff      <= '0;
         flick_tot_ff <= '0;
         doubt_tot_ff <= '0;
         clr_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         pass_ff <= pass_in;
         if (cmd.exec_read) begin
            flick_tot_ff <= at_end ? '0 : flick_tot_in;
            doubt_tot_ff <= at_end ? '0 : doubt_tot_in;
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= stat.clr_last ? '0 : clr_addr_ff + POS_W'(1);
         end
         if (cmd.exec_read) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff  <= action_type'(req_tuser);
         data_ff    <= req_tdata[7:0];
         rd_data_ff <= vote_mem[pos_ff];
      end
      if (cmd.clr_step) begin
         vote_mem[clr_addr_ff] <= '0;
      end else if (cmd.exec_vote) begin
         vote_mem[pos_ff] <= vote_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_read) begin
         out_byte_ff      <= rebuilt;
         out_flick_ff     <= flick_cnt;
         out_doubt_ff     <= doubt_cnt;
         out_last_ff      <= at_end;
         out_status_ff    <= at_end ? status : SECTOR_FAILED;
         out_flick_tot_ff <= at_end ? flick_tot_in : '0;
         out_doubt_tot_ff <= at_end ? doubt_tot_in : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0000, out_doubt_tot_ff, out_flick_tot_ff, out_status_ff,
                        out_doubt_ff, out_flick_ff, out_byte_ff};

endmodule

// File: rtl/core/sector_bit_majority_voter.sv
// channel   dir  ports                        contents
// req_      in   tvalid tready tdata tuser    tdata: data_byte; tuser: action
// rsp_      out  tvalid tready tdata tlast    tdata: byte, flicker, doubtful, status, totals
//
// each request has a read step for the counter row of the current position, then a step
// that updates it or rebuilds the byte; the single-port vote memory sets this.
// after reset and after the final byte of a readout, a clearing pass zeroes the
// vote memory one row a cycle, all SECTOR_BYTES (512) rows, with req_tready low.
// a readout waits in its rebuild step while the result register is still full.
module sector_bit_majority_voter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sbmv_pkg::REQ_TDATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  logic                             req_tuser,   // [0] action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] result_byte, [11:8] flicker_bits, [15:12] doubtful_bits,
   // [17:16] sector_status, [30:18] sector_flicker_total, [43:31] sector_doubtful_total
   output logic [sbmv_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast
);
   import sbmv_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sbmv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sbmv_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
